// ===== design/skil_pkg.sv =====
package skil_pkg;

    localparam int IDX_W = 8;
    localparam int VAL_W = 32;
    localparam int TOL_W = 16;
    localparam int CACHE_W = 9;
    // wide enough for a uniform knot (index << FRAC_BITS) plus tolerance, signed
    localparam int CMP_W = 48;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int POS_W = 2;

    localparam int DEF_KNOT_DEPTH = 256;
    localparam int DEF_FRAC_BITS = 16;

    localparam logic [CACHE_W-1:0] CACHE_INVALID = '1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [POS_W-1:0] POS_INSIDE = 2'd0;
    localparam logic [POS_W-1:0] POS_BELOW = 2'd1;
    localparam logic [POS_W-1:0] POS_ABOVE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNIFORM_MODE = 2'd2;

    typedef enum logic [1:0] {
        OFF_ZERO,
        OFF_SUB_TOL,
        OFF_ADD_TOL
    } off_sel_t;

    typedef struct packed {
        off_sel_t              off_sel;
        logic                  uniform;
        logic                  in_range;
        logic [IDX_W-1:0]      idx;
    } cmp_req_t;

endpackage

// ===== design/skil_knot_ram.sv =====
module skil_knot_ram #(
    parameter int KNOT_DEPTH = skil_pkg::DEF_KNOT_DEPTH,
    localparam int AW = (KNOT_DEPTH > 1) ? $clog2(KNOT_DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [AW-1:0]               waddr,
    input  logic [skil_pkg::VAL_W-1:0]  wdata,
    input  logic [AW-1:0]               raddr,
    output logic [skil_pkg::VAL_W-1:0]  rdata
);

    logic [skil_pkg::VAL_W-1:0] mem [KNOT_DEPTH];
    logic [skil_pkg::VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/skil_cmp_unit.sv =====
module skil_cmp_unit #(
    parameter int FRAC_BITS = skil_pkg::DEF_FRAC_BITS
) (
    input  skil_pkg::cmp_req_t                 req,
    input  logic signed [skil_pkg::VAL_W-1:0]  knot_raw,
    input  logic [skil_pkg::TOL_W-1:0]         tol,
    input  logic signed [skil_pkg::VAL_W-1:0]  t,
    output logic                               lt,
    output logic                               gt
);

    logic signed [skil_pkg::CMP_W-1:0] knot_ext;
    logic signed [skil_pkg::CMP_W-1:0] tol_ext;
    logic signed [skil_pkg::CMP_W-1:0] bound;
    logic signed [skil_pkg::CMP_W-1:0] t_ext;

    always_comb
    begin
        if (req.uniform)
        begin
            knot_ext = signed'(skil_pkg::CMP_W'(req.idx) << FRAC_BITS);
        end
        else if (req.in_range)
        begin
            knot_ext = skil_pkg::CMP_W'(knot_raw);
        end
        else
        begin
            knot_ext = '0;
        end
        tol_ext = signed'(skil_pkg::CMP_W'(tol));
        case (req.off_sel)
            skil_pkg::OFF_SUB_TOL: bound = knot_ext - tol_ext;
            skil_pkg::OFF_ADD_TOL: bound = knot_ext + tol_ext;
            default:               bound = knot_ext;
        endcase
        t_ext = skil_pkg::CMP_W'(t);
        lt = t_ext < bound;
        gt = t_ext > bound;
    end

endmodule

// ===== design/spline_knot_interval_lookup_unit.sv =====
// Knot span search. A load (operation 0) writes one knot and gives no
// result; busy stays low. A lookup (operation 1) keeps busy high while it
// runs up to two range checks, two cache checks, two end checks of the search
// and then bisection steps, one per cycle, all through the one knot RAM read
// port and one shared comparator. The result appears on piece_index, position
// and cache_hit for one cycle with done high; the receiver cannot stall it, and
// a new start may be taken in that same cycle. Knots must be written before
// lookups that read them. Configuration writes are always ready.
module spline_knot_interval_lookup_unit #(
    parameter int KNOT_DEPTH = skil_pkg::DEF_KNOT_DEPTH,
    parameter int FRAC_BITS = skil_pkg::DEF_FRAC_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  operation,
    input  logic [skil_pkg::IDX_W-1:0]            knot_slot,
    input  logic signed [skil_pkg::VAL_W-1:0]     value,
    output logic                                  done,
    output logic [skil_pkg::IDX_W-1:0]            piece_index,
    output logic [skil_pkg::POS_W-1:0]            position,
    output logic                                  cache_hit,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [skil_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [skil_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int AW = (KNOT_DEPTH > 1) ? $clog2(KNOT_DEPTH) : 1;
    localparam int IW = skil_pkg::IDX_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK_LO,
        ST_CHK_HI,
        ST_CACHE_LO,
        ST_CACHE_HI,
        ST_SRCH_LO,
        ST_SRCH_HI,
        ST_BISECT
    } state_t;

    state_t state_reg, state_next;

    logic [IW-1:0]                   interval_count_reg;
    logic [skil_pkg::TOL_W-1:0]      tolerance_reg;
    logic                            uniform_mode_reg;

    logic [skil_pkg::CACHE_W-1:0]    cache_reg, cache_next;
    logic [IW-1:0]                   rd_idx_reg, rd_idx_next;
    logic [IW-1:0]                   lo_reg, lo_next;
    logic [IW-1:0]                   hi_reg, hi_next;
    logic signed [skil_pkg::VAL_W-1:0] t_reg, t_next;
    logic                            done_reg, done_next;
    logic [IW-1:0]                   piece_reg, piece_next;
    logic [skil_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic                            hit_reg, hit_next;

    logic [IW-1:0]                   n_eff;
    logic [IW-1:0]                   uni_idx;
    logic signed [skil_pkg::VAL_W-1:0] uni_q;
    logic [IW-1:0]                   bis_lo, bis_hi, bis_mid, bis_gap;
    logic                            accept;
    logic                            ram_we;
    logic [skil_pkg::VAL_W-1:0]      ram_rdata;
    skil_pkg::off_sel_t              off_sel;
    skil_pkg::cmp_req_t              cmp_req;
    logic                            cmp_lt, cmp_gt;

    assign accept = start && !busy;
    assign busy = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign n_eff = (interval_count_reg == '0) ? IW'(1) : interval_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_count_reg <= IW'(1);
            tolerance_reg <= '0;
            uniform_mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                skil_pkg::REG_INTERVAL_COUNT: interval_count_reg <= cfg_data[IW-1:0];
                skil_pkg::REG_TOLERANCE:      tolerance_reg <= cfg_data[skil_pkg::TOL_W-1:0];
                skil_pkg::REG_UNIFORM_MODE:   uniform_mode_reg <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    assign ram_we = accept && (operation == skil_pkg::OP_LOAD)
                    && (32'(knot_slot) < KNOT_DEPTH);

    skil_knot_ram #(
        .KNOT_DEPTH(KNOT_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(knot_slot)),
        .wdata (value),
        .raddr (AW'(rd_idx_next)),
        .rdata (ram_rdata)
    );

    assign cmp_req = '{off_sel:  off_sel,
                       uniform:  uniform_mode_reg,
                       in_range: (32'(rd_idx_reg) < KNOT_DEPTH),
                       idx:      rd_idx_reg};

    skil_cmp_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) u_cmp (
        .req      (cmp_req),
        .knot_raw (signed'(ram_rdata)),
        .tol      (tolerance_reg),
        .t        (t_reg),
        .lt       (cmp_lt),
        .gt       (cmp_gt)
    );

    // uniform floor, clamped to 0 .. n-1
    always_comb
    begin
        uni_q = t_reg >>> FRAC_BITS;
        if (t_reg[skil_pkg::VAL_W-1])
        begin
            uni_idx = '0;
        end
        else if (unsigned'(uni_q) >= 32'(n_eff))
        begin
            uni_idx = n_eff - IW'(1);
        end
        else
        begin
            uni_idx = uni_q[IW-1:0];
        end
    end

    // one bisection step on the knot at rd_idx (the current mid)
    always_comb
    begin
        bis_lo = cmp_lt ? lo_reg : rd_idx_reg;
        bis_hi = cmp_lt ? rd_idx_reg : hi_reg;
        bis_gap = bis_hi - bis_lo;
        bis_mid = IW'(((IW+1)'(bis_lo) + (IW+1)'(bis_hi)) >> 1);
    end

    always_comb
    begin
        state_next = state_reg;
        rd_idx_next = rd_idx_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        t_next = t_reg;
        cache_next = cache_reg;
        done_next = 1'b0;
        piece_next = piece_reg;
        pos_next = pos_reg;
        hit_next = hit_reg;
        off_sel = skil_pkg::OFF_ZERO;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (operation == skil_pkg::OP_LOOKUP)
                    begin
                        t_next = value;
                        rd_idx_next = '0;
                        state_next = ST_CHK_LO;
                    end
                    else
                    begin
                        cache_next = skil_pkg::CACHE_INVALID;
                    end
                end
            end
            ST_CHK_LO:
            begin
                off_sel = skil_pkg::OFF_SUB_TOL;
                if (cmp_lt)
                begin
                    done_next = 1'b1;
                    piece_next = '0;
                    pos_next = skil_pkg::POS_BELOW;
                    hit_next = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_idx_next = n_eff;
                    state_next = ST_CHK_HI;
                end
            end
            ST_CHK_HI:
            begin
                off_sel = skil_pkg::OFF_ADD_TOL;
                if (cmp_gt)
                begin
                    done_next = 1'b1;
                    piece_next = n_eff - IW'(1);
                    pos_next = skil_pkg::POS_ABOVE;
                    hit_next = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (uniform_mode_reg)
                begin
                    done_next = 1'b1;
                    piece_next = uni_idx;
                    pos_next = skil_pkg::POS_INSIDE;
                    hit_next = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (cache_reg < {1'b0, n_eff})
                begin
                    rd_idx_next = cache_reg[IW-1:0];
                    state_next = ST_CACHE_LO;
                end
                else
                begin
                    rd_idx_next = '0;
                    state_next = ST_SRCH_LO;
                end
            end
            ST_CACHE_LO:
            begin
                if (cmp_lt)
                begin
                    rd_idx_next = '0;
                    state_next = ST_SRCH_LO;
                end
                else
                begin
                    rd_idx_next = cache_reg[IW-1:0] + IW'(1);
                    state_next = ST_CACHE_HI;
                end
            end
            ST_CACHE_HI:
            begin
                if (cmp_lt)
                begin
                    done_next = 1'b1;
                    piece_next = cache_reg[IW-1:0];
                    pos_next = skil_pkg::POS_INSIDE;
                    hit_next = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_idx_next = '0;
                    state_next = ST_SRCH_LO;
                end
            end
            ST_SRCH_LO:
            begin
                if (cmp_lt)
                begin
                    done_next = 1'b1;
                    piece_next = '0;
                    pos_next = skil_pkg::POS_INSIDE;
                    hit_next = 1'b0;
                    cache_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_idx_next = n_eff;
                    state_next = ST_SRCH_HI;
                end
            end
            ST_SRCH_HI:
            begin
                if (!cmp_lt || n_eff == IW'(1))
                begin
                    // t at or past the last knot, or a single piece: clamp to n-1
                    done_next = 1'b1;
                    piece_next = n_eff - IW'(1);
                    pos_next = skil_pkg::POS_INSIDE;
                    hit_next = 1'b0;
                    cache_next = {1'b0, n_eff - IW'(1)};
                    state_next = ST_IDLE;
                end
                else
                begin
                    lo_next = '0;
                    hi_next = n_eff;
                    rd_idx_next = n_eff >> 1;
                    state_next = ST_BISECT;
                end
            end
            ST_BISECT:
            begin
                lo_next = bis_lo;
                hi_next = bis_hi;
                if (bis_gap > IW'(1))
                begin
                    rd_idx_next = bis_mid;
                end
                else
                begin
                    done_next = 1'b1;
                    piece_next = bis_lo;
                    pos_next = skil_pkg::POS_INSIDE;
                    hit_next = 1'b0;
                    cache_next = {1'b0, bis_lo};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cache_reg <= skil_pkg::CACHE_INVALID;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cache_reg <= cache_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        t_reg <= t_next;
        piece_reg <= piece_next;
        pos_reg <= pos_next;
        hit_reg <= hit_next;
    end

    assign done = done_reg;
    assign piece_index = piece_reg;
    assign position = pos_reg;
    assign cache_hit = hit_reg;

endmodule

// ===== design/skil_checker.sv =====
module skil_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              operation,
    input  logic                              done,
    input  logic [skil_pkg::IDX_W-1:0]        piece_index,
    input  logic [skil_pkg::POS_W-1:0]        position,
    input  logic                              cache_hit
);

    // a result closes the lookup: the unit is free again in that cycle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // a cache answer is only given inside the knot range
    a_hit_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (done && cache_hit) |-> (position == skil_pkg::POS_INSIDE))
        else $error("cache hit outside range");

    a_below_piece0: assert property (@(posedge clk) disable iff (!rst_n)
        (done && position == skil_pkg::POS_BELOW) |-> (piece_index == '0))
        else $error("below range but piece not zero");

    // a load transfer gives no result and leaves the unit free
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == skil_pkg::OP_LOAD) |=> (!busy && !done))
        else $error("load caused activity");

    a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == skil_pkg::OP_LOOKUP) |=> (busy && !done))
        else $error("lookup not taken");

endmodule

bind spline_knot_interval_lookup_unit skil_checker u_skil_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .operation   (operation),
    .done        (done),
    .piece_index (piece_index),
    .position    (position),
    .cache_hit   (cache_hit)
);

// ===== test/spline_knot_interval_lookup_unit_tb.sv =====
module spline_knot_interval_lookup_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD = 10;
    localparam int FRAC = skil_pkg::DEF_FRAC_BITS;
    localparam int NUM_KNOTS = skil_pkg::DEF_KNOT_DEPTH;
    localparam int RANDOM_LOOKUPS = 360;
    localparam int DRAIN_CYCLES = 16;
    localparam int IDX_W = skil_pkg::IDX_W;
    localparam int VAL_W = skil_pkg::VAL_W;
    localparam int POS_W = skil_pkg::POS_W;
    localparam int TOL_W = skil_pkg::TOL_W;
    localparam int CACHE_W = skil_pkg::CACHE_W;
    localparam int CFG_IDX_W = skil_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = skil_pkg::CFG_DATA_W;
    // index 3 is not a register; writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [IDX_W-1:0] piece;
        logic [POS_W-1:0] pos;
        logic             hit;
    } piece_t;

    class piece_scoreboard;
        logic [VAL_W-1:0]   knots [NUM_KNOTS];
        logic [CACHE_W-1:0] remembered;
        logic [IDX_W-1:0]   count_reg;
        logic [TOL_W-1:0]   tol_reg;
        logic               uniform_reg;
        piece_t             expected_pieces [$];
        int                 errors;

        function new();
            foreach (knots[i])
                knots[i] = '0;
            remembered = skil_pkg::CACHE_INVALID;
            count_reg = 8'd1;
            tol_reg = '0;
            uniform_reg = 1'b0;
            errors = 0;
        endfunction

        function longint knot_at(int unsigned i);
            if (uniform_reg)
                return longint'(i) << FRAC;
            if (i < NUM_KNOTS)
                return longint'($signed(knots[i]));
            return 0;
        endfunction

        function int unsigned pieces();
            return (count_reg == 0) ? 1 : int'(count_reg);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                skil_pkg::REG_INTERVAL_COUNT: count_reg = data[IDX_W-1:0];
                skil_pkg::REG_TOLERANCE:      tol_reg = data[TOL_W-1:0];
                skil_pkg::REG_UNIFORM_MODE:   uniform_reg = data[0];
                default: ;
            endcase
        endfunction

        // largest knot not above t, bisection keeping knot[lo] <= t
        function int unsigned bisect(longint t, int unsigned n);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo = 0;
            hi = n;
            if (t < knot_at(0))
                return 0;
            if (t >= knot_at(n))
                return n;
            while (hi - lo > 1)
            begin
                mid = (lo + hi) / 2;
                if (knot_at(mid) <= t)
                    lo = mid;
                else
                    hi = mid;
            end
            return lo;
        endfunction

        function piece_t predict_piece(longint t);
            piece_t      r;
            int unsigned n;
            int unsigned c;
            int unsigned idx;
            longint      q;
            n = pieces();
            r = '0;
            if (t < knot_at(0) - longint'(tol_reg))
            begin
                r.pos = skil_pkg::POS_BELOW;
            end
            else if (t > knot_at(n) + longint'(tol_reg))
            begin
                r.piece = IDX_W'(n - 1);
                r.pos = skil_pkg::POS_ABOVE;
            end
            else if (uniform_reg)
            begin
                q = t >>> FRAC;
                if (q < 0)
                    q = 0;
                if (q >= longint'(n))
                    q = longint'(n) - 1;
                r.piece = IDX_W'(q);
                r.pos = skil_pkg::POS_INSIDE;
            end
            else
            begin
                c = remembered;
                if (c < n && knot_at(c) <= t && t < knot_at(c + 1))
                begin
                    r.piece = IDX_W'(c);
                    r.hit = 1'b1;
                end
                else
                begin
                    idx = bisect(t, n);
                    if (idx >= n)
                        idx = n - 1;
                    remembered = CACHE_W'(idx);
                    r.piece = IDX_W'(idx);
                end
                r.pos = skil_pkg::POS_INSIDE;
            end
            return r;
        endfunction

        function void note_item(logic op, logic [IDX_W-1:0] slot, logic [VAL_W-1:0] val);
            if (op == skil_pkg::OP_LOAD)
            begin
                knots[slot] = val;
                remembered = skil_pkg::CACHE_INVALID;
            end
            else
            begin
                expected_pieces.push_back(predict_piece(longint'($signed(val))));
            end
        endfunction

        function void check_piece(piece_t got);
            piece_t want;
            if (expected_pieces.size() == 0)
            begin
                $display("%0t: result with none expected: piece %0d position %0d hit %0d",
                         $time, got.piece, got.pos, got.hit);
                errors++;
                return;
            end
            want = expected_pieces.pop_front();
            if (got.piece !== want.piece)
            begin
                $display("%0t: piece_index expected %0d actual %0d", $time, want.piece, got.piece);
                errors++;
            end
            if (got.pos !== want.pos)
            begin
                $display("%0t: position expected %0d actual %0d", $time, want.pos, got.pos);
                errors++;
            end
            if (got.hit !== want.hit)
            begin
                $display("%0t: cache_hit expected %0d actual %0d", $time, want.hit, got.hit);
                errors++;
            end
        endfunction

        function bit drained();
            return expected_pieces.size() == 0;
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic                        operation = skil_pkg::OP_LOAD;
    logic [IDX_W-1:0]            knot_slot = '0;
    logic signed [VAL_W-1:0]     value = '0;
    logic                        done;
    logic [IDX_W-1:0]            piece_index;
    logic [POS_W-1:0]            position;
    logic                        cache_hit;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;

    piece_scoreboard board;
    bit                          written [NUM_KNOTS];
    bit                          steady;
    int                          lookups_done;

    spline_knot_interval_lookup_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .knot_slot   (knot_slot),
        .value       (value),
        .done        (done),
        .piece_index (piece_index),
        .position    (position),
        .cache_hit   (cache_hit),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_piece(piece_t'({piece_index, position, cache_hit}));
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VAL_W-1:0] clamp32(longint x);
        if (x > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (x < -64'sd2147483648)
            return 32'h8000_0000;
        return x[VAL_W-1:0];
    endfunction

    function automatic longint pick_between(longint lo, longint hi);
        longint unsigned r;
        longint          span;
        if (hi <= lo)
            return lo;
        span = hi - lo + 1;
        r = {$urandom, $urandom};
        return lo + longint'(r % span);
    endfunction

    function automatic bit knots_ready(int unsigned n);
        for (int i = 0; i <= n; i++)
            if (!written[i])
                return 1'b0;
        return 1'b1;
    endfunction

    // start is left high after a transfer so a back-to-back item needs no toggle
    task automatic send(logic op, logic [IDX_W-1:0] slot, logic [VAL_W-1:0] val);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        knot_slot <= slot;
        value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_item(op, slot, val);
    endtask

    task automatic load_knot(int unsigned slot, logic [VAL_W-1:0] val);
        written[slot] = 1'b1;
        send(skil_pkg::OP_LOAD, IDX_W'(slot), val);
    endtask

    task automatic lookup(longint t);
        send(skil_pkg::OP_LOOKUP, IDX_W'($urandom), clamp32(t));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (!steady && $urandom_range(0, 2) == 0)
        begin
            cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // loads give no result, so allow for one still in flight
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (!board.drained());
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] count_data, logic [CFG_DATA_W-1:0] tol_data,
                             logic [CFG_DATA_W-1:0] uni_data, bit spare);
        settle();
        if ($urandom_range(0, 1))
        begin
            write_reg(skil_pkg::REG_UNIFORM_MODE, uni_data);
            write_reg(skil_pkg::REG_INTERVAL_COUNT, count_data);
        end
        else
        begin
            write_reg(skil_pkg::REG_INTERVAL_COUNT, count_data);
            write_reg(skil_pkg::REG_UNIFORM_MODE, uni_data);
        end
        write_reg(skil_pkg::REG_TOLERANCE, tol_data);
        if (spare)
            write_reg(REG_SPARE, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // ascending knots with the odd repeated value, or now and then pure noise
    task automatic build_knots(int unsigned n, bit messy);
        logic [VAL_W-1:0] vals [NUM_KNOTS];
        longint           k;
        int unsigned      s;
        k = pick_between(-(longint'(1) << 29), longint'(1) << 29);
        s = $urandom_range(0, 22);
        for (int i = 0; i <= n; i++)
        begin
            if (messy)
                vals[i] = $urandom;
            else
                vals[i] = clamp32(k);
            if ($urandom_range(0, 9) != 0)
                k += pick_between(1, longint'(1) << s);
        end
        if ($urandom_range(0, 1))
            for (int i = 0; i <= n; i++)
                load_knot(i, vals[i]);
        else
            for (int i = n; i >= 0; i--)
                load_knot(i, vals[i]);
        if (n < NUM_KNOTS - 1)
            repeat ($urandom_range(0, 3)) load_knot($urandom_range(n + 1, NUM_KNOTS - 1), $urandom);
    endtask

    task automatic random_step(int unsigned n, longint tol);
        int unsigned r;
        int unsigned j;
        int unsigned slot;
        longint      lo_edge;
        longint      hi_edge;
        longint      lo;
        longint      hi;
        lo_edge = board.knot_at(0) - tol;
        hi_edge = board.knot_at(n) + tol;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            // mostly stay in the cached piece to get hits
            if (r < 30 && board.remembered < n)
                j = board.remembered;
            else
                j = $urandom_range(0, n - 1);
            lookup(pick_between(board.knot_at(j), board.knot_at(j + 1) - 1));
        end
        else if (r < 65)
        begin
            lookup(board.knot_at($urandom_range(0, n)));
        end
        else if (r < 77)
        begin
            case ($urandom_range(0, 3))
                0: lookup(lo_edge - 1);
                1: lookup(lo_edge);
                2: lookup(hi_edge);
                default: lookup(hi_edge + 1);
            endcase
        end
        else if (r < 90)
        begin
            lookup(longint'($signed(VAL_W'($urandom))));
        end
        else if (r < 95)
        begin
            case ($urandom_range(0, 3))
                0: lookup(-64'sd2147483648);
                1: lookup(64'sd2147483647);
                2: lookup(0);
                default: lookup(-1);
            endcase
        end
        else
        begin
            // rewrite a knot between its neighbours; drops the cache
            slot = $urandom_range(0, n);
            lo = (slot > 0) ? board.knot_at(slot - 1) : board.knot_at(0) - 65536;
            hi = (slot < n) ? board.knot_at(slot + 1) : board.knot_at(n) + 65536;
            load_knot(slot, clamp32(pick_between(lo, hi)));
            return;
        end
        lookups_done++;
    endtask

    initial
    begin
        #(20_000_000);
        $display("spline_knot_interval_lookup_unit_tb: done, errors");
        $finish;
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] count_data;
        logic [CFG_DATA_W-1:0] tol_data;
        logic [CFG_DATA_W-1:0] uni_data;
        int unsigned           n;
        int unsigned           phase;
        int unsigned           r;

        board = new();
        steady = 1'b0;
        lookups_done = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one piece, no slack, table mode
        load_knot(0, 32'h0000_0000);
        load_knot(1, 32'h0001_0000);
        lookup(0);
        lookup(32'h0000_8000);
        lookup(-1);
        lookup(32'h0001_0000);
        lookup(32'h0001_0001);
        lookup(-64'sd2147483648);
        lookup(64'sd2147483647);
        load_knot(1, 32'h0002_0000);
        lookup(32'h0001_8000);
        lookup(32'h0001_FFFF);

        // zero count behaves as one piece; full slack
        configure(16'h0000, 16'hFFFF, 16'h0000, 1'b1);
        lookup(-65535);
        lookup(-65536);
        lookup(32'h0002_FFFF);
        lookup(32'h0003_0000);
        load_knot(255, 32'h8000_0000);
        load_knot(254, 32'h7FFF_FFFF);

        configure(16'h00FF, 16'hFFFF, 16'h0001, 1'b0);
        lookup(-1);
        lookup(32'h0003_8000);
        lookup(32'h00FF_FFFF);
        lookup(-64'sd2147483648);
        lookup(64'sd2147483647);

        phase = 0;
        while (lookups_done < RANDOM_LOOKUPS)
        begin
            case (phase)
                0:
                begin
                    count_data = 16'd255;
                    tol_data = 16'd0;
                    uni_data = 16'd0;
                end
                1:
                begin
                    count_data = 16'd1;
                    tol_data = 16'hFFFF;
                    uni_data = 16'd0;
                end
                2:
                begin
                    count_data = 16'd0;
                    tol_data = CFG_DATA_W'($urandom);
                    uni_data = 16'd0;
                end
                3:
                begin
                    count_data = 16'd255;
                    tol_data = 16'hFFFF;
                    uni_data = 16'd1;
                end
                4:
                begin
                    count_data = 16'd2;
                    tol_data = 16'd1;
                    uni_data = 16'd0;
                end
                default:
                begin
                    r = $urandom_range(0, 7);
                    if (r < 2)
                        count_data = CFG_DATA_W'($urandom_range(1, 8));
                    else if (r < 4)
                        count_data = CFG_DATA_W'($urandom_range(1, 255));
                    else if (r == 4)
                        count_data = 16'd255;
                    else if (r == 5)
                        count_data = 16'd0;
                    else
                        count_data = CFG_DATA_W'($urandom_range(9, 40));
                    r = $urandom_range(0, 7);
                    tol_data = (r < 2) ? 16'd0 : (r == 2) ? 16'hFFFF : 16'($urandom);
                    uni_data = ($urandom_range(0, 4) == 0) ? 16'd1 : 16'd0;
                end
            endcase
            // bits above the register width are don't-care
            if ($urandom_range(0, 2) == 0)
            begin
                count_data[CFG_DATA_W-1:IDX_W] = (CFG_DATA_W - IDX_W)'($urandom);
                uni_data[CFG_DATA_W-1:1] = (CFG_DATA_W - 1)'($urandom);
            end
            n = (count_data[IDX_W-1:0] == 0) ? 1 : int'(count_data[IDX_W-1:0]);
            steady = ($urandom_range(0, 3) == 0);
            configure(count_data, tol_data, uni_data, phase % 3 == 0);

            if (uni_data[0])
                repeat ($urandom_range(0, 3)) load_knot($urandom_range(0, NUM_KNOTS - 1), $urandom);
            else if (!(knots_ready(n) && $urandom_range(0, 3) == 0))
                build_knots(n, $urandom_range(0, 7) == 0);

            repeat ($urandom_range(50, 90)) random_step(n, longint'(tol_data));
            phase++;
        end

        settle();
        if (board.errors == 0)
            $display("spline_knot_interval_lookup_unit_tb: done, clean");
        else
            $display("spline_knot_interval_lookup_unit_tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/skil_pkg.sv
design/skil_knot_ram.sv
design/skil_cmp_unit.sv
design/spline_knot_interval_lookup_unit.sv
design/skil_checker.sv
test/spline_knot_interval_lookup_unit_tb.sv
